>>> rtl/gtfr_pkg.sv
`default_nettype none
package gtfr_pkg;

	localparam int DEF_SCREEN_WIDTH  = 250;
	localparam int DEF_SCREEN_HEIGHT = 122;
	localparam int DEF_ROW_BYTES     = 16;

	// Wide enough for any byte index over the full parameter range.
	localparam int IDX_W   = 18;
	localparam int COORD_W = 14;
	localparam int XY_W    = 11;
	localparam int SCALE_W = 4;
	localparam int CODE_W  = 8;
	localparam int BYTE_W  = 8;
	localparam int RIDX_W  = 12;
	localparam int CMD_W   = 3;
	localparam int GLYPH_W = 40;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL  = 3'd0,
		CMD_PIXEL = 3'd1,
		CMD_TEXT  = 3'd2,
		CMD_CHAR  = 3'd3,
		CMD_READ  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic load;
		logic sweep_wr;
		logic dot_next;
		logic dot_skip;
		logic calc_coord;
		logic calc_addr;
		logic pix_wr;
		logic cursor_upd;
		logic rd_capture;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic dot_lit;
		logic row_last;
		logic sub_last;
		logic halted;
	} dp_sts_t;

	// Five column bytes, column 0 in the top byte; bit n of a column is glyph row n.
	function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [6:0] idx);
		logic [GLYPH_W-1:0] g;
		unique case (idx)
			7'd0:  g = 40'h0000000000;
			7'd1:  g = 40'h00005F0000;
			7'd2:  g = 40'h0007000700;
			7'd3:  g = 40'h147F147F14;
			7'd4:  g = 40'h242A7F2A12;
			7'd5:  g = 40'h2313086462;
			7'd6:  g = 40'h3649562050;
			7'd7:  g = 40'h0008070300;
			7'd8:  g = 40'h001C224100;
			7'd9:  g = 40'h0041221C00;
			7'd10: g = 40'h2A1C7F1C2A;
			7'd11: g = 40'h08083E0808;
			7'd12: g = 40'h0080703000;
			7'd13: g = 40'h0808080808;
			7'd14: g = 40'h0000606000;
			7'd15: g = 40'h2010080402;
			7'd16: g = 40'h3E5149453E;
			7'd17: g = 40'h00427F4000;
			7'd18: g = 40'h7249494946;
			7'd19: g = 40'h2141494D33;
			7'd20: g = 40'h1814127F10;
			7'd21: g = 40'h2745454539;
			7'd22: g = 40'h3C4A494931;
			7'd23: g = 40'h4121110907;
			7'd24: g = 40'h3649494936;
			7'd25: g = 40'h464949291E;
			7'd26: g = 40'h0000140000;
			7'd27: g = 40'h0040340000;
			7'd28: g = 40'h0008142241;
			7'd29: g = 40'h1414141414;
			7'd30: g = 40'h4122140800;
			7'd31: g = 40'h0201590906;
			7'd32: g = 40'h3E415D594E;
			7'd33: g = 40'h7C1211127C;
			7'd34: g = 40'h7F49494936;
			7'd35: g = 40'h3E41414122;
			7'd36: g = 40'h7F4141413E;
			7'd37: g = 40'h7F49494941;
			7'd38: g = 40'h7F09090901;
			7'd39: g = 40'h3E41415173;
			7'd40: g = 40'h7F0808087F;
			7'd41: g = 40'h00417F4100;
			7'd42: g = 40'h2040413F01;
			7'd43: g = 40'h7F08142241;
			7'd44: g = 40'h7F40404040;
			7'd45: g = 40'h7F021C027F;
			7'd46: g = 40'h7F0408107F;
			7'd47: g = 40'h3E4141413E;
			7'd48: g = 40'h7F09090906;
			7'd49: g = 40'h3E4151215E;
			7'd50: g = 40'h7F09192946;
			7'd51: g = 40'h2649494932;
			7'd52: g = 40'h03017F0103;
			7'd53: g = 40'h3F4040403F;
			7'd54: g = 40'h1F2040201F;
			7'd55: g = 40'h3F4038403F;
			7'd56: g = 40'h6314081463;
			7'd57: g = 40'h0304780403;
			7'd58: g = 40'h6159494D43;
			7'd59: g = 40'h007F414141;
			7'd60: g = 40'h0204081020;
			7'd61: g = 40'h004141417F;
			7'd62: g = 40'h0402010204;
			7'd63: g = 40'h4040404040;
			7'd64: g = 40'h0003070800;
			7'd65: g = 40'h2054547840;
			7'd66: g = 40'h7F28444438;
			7'd67: g = 40'h3844444428;
			7'd68: g = 40'h384444287F;
			7'd69: g = 40'h3854545418;
			7'd70: g = 40'h00087E0902;
			7'd71: g = 40'h18A4A49C78;
			7'd72: g = 40'h7F08040478;
			7'd73: g = 40'h00447D4000;
			7'd74: g = 40'h2040403D00;
			7'd75: g = 40'h7F10284400;
			7'd76: g = 40'h00417F4000;
			7'd77: g = 40'h7C04780478;
			7'd78: g = 40'h7C08040478;
			7'd79: g = 40'h3844444438;
			7'd80: g = 40'hFC18242418;
			7'd81: g = 40'h18242418FC;
			7'd82: g = 40'h7C08040408;
			7'd83: g = 40'h4854545424;
			7'd84: g = 40'h04043F4424;
			7'd85: g = 40'h3C4040207C;
			7'd86: g = 40'h1C2040201C;
			7'd87: g = 40'h3C4030403C;
			7'd88: g = 40'h4428102844;
			7'd89: g = 40'h4C9090907C;
			7'd90: g = 40'h4464544C44;
			7'd91: g = 40'h0008364100;
			7'd92: g = 40'h0000770000;
			7'd93: g = 40'h0041360800;
			7'd94: g = 40'h0201020402;
			7'd95: g = 40'h7F7F7F7F7F;
			default: g = 40'h0201590906;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

>>> rtl/gtfr_in_if.sv
`default_nettype none
interface gtfr_in_if;
	logic                                valid;
	logic                                ready;
	logic [gtfr_pkg::CMD_W-1:0]          command;
	logic signed [gtfr_pkg::XY_W-1:0]    x_pos;
	logic signed [gtfr_pkg::XY_W-1:0]    y_pos;
	logic                                pixel_black;
	logic                                fill_white;
	logic [gtfr_pkg::CODE_W-1:0]         char_code;
	logic [gtfr_pkg::SCALE_W-1:0]        text_scale;
	logic [gtfr_pkg::RIDX_W-1:0]         read_index;

	modport source (output valid, command, x_pos, y_pos, pixel_black, fill_white, char_code,
		text_scale, read_index, input ready);
	modport sink (input valid, command, x_pos, y_pos, pixel_black, fill_white, char_code,
		text_scale, read_index, output ready);
endinterface
`default_nettype wire

>>> rtl/gtfr_out_if.sv
`default_nettype none
interface gtfr_out_if;
	logic                         valid;
	logic                         ready;
	logic [gtfr_pkg::BYTE_W-1:0]  read_data;
	logic                         text_stopped;

	modport source (output valid, read_data, text_stopped, input ready);
	modport sink (input valid, read_data, text_stopped, output ready);
endinterface
`default_nettype wire

>>> rtl/gtfr_ram.sv
`default_nettype none
module gtfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4000
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> rtl/gtfr_datapath.sv
`default_nettype none
module gtfr_datapath #(
	parameter int SCREEN_WIDTH  = gtfr_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = gtfr_pkg::DEF_SCREEN_HEIGHT,
	parameter int ROW_BYTES     = gtfr_pkg::DEF_ROW_BYTES
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire gtfr_pkg::dp_cmd_t                     cmd,
	output gtfr_pkg::dp_sts_t                          sts,
	input  wire logic [gtfr_pkg::CMD_W-1:0]            command,
	input  wire logic signed [gtfr_pkg::XY_W-1:0]      x_pos,
	input  wire logic signed [gtfr_pkg::XY_W-1:0]      y_pos,
	input  wire logic                                  pixel_black,
	input  wire logic                                  fill_white,
	input  wire logic [gtfr_pkg::CODE_W-1:0]           char_code,
	input  wire logic [gtfr_pkg::SCALE_W-1:0]          text_scale,
	input  wire logic [gtfr_pkg::RIDX_W-1:0]           read_index,
	output logic [gtfr_pkg::BYTE_W-1:0]                read_data,
	output logic                                       text_stopped
);
	localparam int FRAME_BYTES = SCREEN_WIDTH * ROW_BYTES;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int CW          = gtfr_pkg::COORD_W;
	localparam int IW          = gtfr_pkg::IDX_W;
	localparam int SW          = gtfr_pkg::SCALE_W;
	localparam int BW          = gtfr_pkg::BYTE_W;

	logic [ADDR_W-1:0]   sweep_q;
	logic [BW-1:0]       fill_q;
	logic signed [CW-1:0] cur_x_q, cur_y_q;
	logic [SW-1:0]       scale_q;
	logic                halted_q;
	logic [gtfr_pkg::GLYPH_W-1:0] glyph_q;
	logic [2:0]          col_q, row_q;
	logic [SW-1:0]       dx_q, dy_q;
	logic signed [CW-1:0] px_q, py_q;
	logic                black_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                ok_q;
	logic [BW-1:0]       bit_q;
	logic                rd_ok_q;
	logic [BW-1:0]       hold_q;
	logic [BW-1:0]       out_data_q;
	logic                out_stop_q;

	logic [6:0]          glyph_idx;
	logic [BW-1:0]       line;
	logic [SW-1:0]       s_max;
	logic [6:0]          col_off;
	logic                on_screen;
	logic signed [CW-1:0] panel_col;
	logic [CW-4:0]       byte_col;
	logic [IW-1:0]       idx;
	logic [IW-1:0]       ridx_ext;
	logic signed [CW-1:0] s_ext, cw_s, lf_s, hh_s, nx, ny;
	logic                wrap;
	logic [ADDR_W-1:0]   ram_addr;
	logic                ram_we;
	logic [BW-1:0]       ram_wdata, ram_rdata;

	always_comb begin
		if (char_code < 8'd32 || char_code > 8'd127) begin
			glyph_idx = 7'd31;
		end else begin
			glyph_idx = 7'(char_code - 8'd32);
		end
	end

	always_comb begin
		unique case (col_q)
			3'd0: line = glyph_q[39:32];
			3'd1: line = glyph_q[31:24];
			3'd2: line = glyph_q[23:16];
			3'd3: line = glyph_q[15:8];
			3'd4: line = glyph_q[7:0];
			default: line = '0;
		endcase
	end

	assign s_max          = scale_q - SW'(1);
	assign sts.dot_lit    = line[row_q] && (scale_q != '0);
	assign sts.row_last   = (col_q == 3'd4) && (row_q == 3'd6);
	assign sts.sub_last   = (dx_q == s_max) && (dy_q == s_max);
	assign sts.sweep_last = (sweep_q == ADDR_W'(FRAME_BYTES - 1));
	assign sts.halted     = halted_q;

	assign col_off = 7'(col_q * scale_q);

	// Landscape to panel order: raw row is x, raw column counts down from the far edge.
	assign on_screen = (px_q >= 0) && (px_q < $signed(CW'(SCREEN_WIDTH))) &&
		(py_q >= 0) && (py_q < $signed(CW'(SCREEN_HEIGHT)));
	assign panel_col = $signed(CW'(SCREEN_HEIGHT - 1)) - py_q;
	assign byte_col  = panel_col[CW-1:3];
	assign idx       = IW'(px_q) * IW'(ROW_BYTES) + IW'(byte_col);
	assign ridx_ext  = IW'(read_index);

	assign s_ext = $signed(CW'(scale_q));
	assign cw_s  = (s_ext <<< 2) + (s_ext <<< 1);
	assign lf_s  = (s_ext <<< 3) + (s_ext <<< 1);
	assign hh_s  = s_ext <<< 3;
	assign nx    = cur_x_q + cw_s;
	assign wrap  = nx > ($signed(CW'(SCREEN_WIDTH)) - cw_s);
	assign ny    = wrap ? (cur_y_q + lf_s) : cur_y_q;

	always_comb begin
		ram_we    = cmd.sweep_wr || (cmd.pix_wr && ok_q);
		ram_wdata = black_q ? (ram_rdata & ~bit_q) : (ram_rdata | bit_q);
		ram_addr  = addr_q;
		if (cmd.sweep_wr) begin
			ram_addr  = sweep_q;
			ram_wdata = fill_q;
		end else if (cmd.load) begin
			ram_addr = ridx_ext[ADDR_W-1:0];
		end
	end

	gtfr_ram #(.WIDTH(BW), .DEPTH(FRAME_BYTES)) u_frame (
		.clk   (clk),
		.addr  (ram_addr),
		.we    (ram_we),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q    <= '0;
			fill_q     <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			scale_q    <= SW'(1);
			halted_q   <= 1'b0;
			out_data_q <= '0;
			out_stop_q <= 1'b0;
		end else begin
			if (cmd.sweep_wr) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
			if (cmd.load) begin
				hold_q <= '0;
				unique case (command)
					gtfr_pkg::CMD_FILL: begin
						fill_q  <= fill_white ? '1 : '0;
						sweep_q <= '0;
					end
					gtfr_pkg::CMD_PIXEL: begin
						px_q    <= CW'(x_pos);
						py_q    <= CW'(y_pos);
						black_q <= pixel_black;
					end
					gtfr_pkg::CMD_TEXT: begin
						cur_x_q  <= CW'(x_pos);
						cur_y_q  <= CW'(y_pos);
						scale_q  <= text_scale;
						halted_q <= 1'b0;
					end
					gtfr_pkg::CMD_CHAR: begin
						glyph_q <= gtfr_pkg::glyph_bits(glyph_idx);
						col_q   <= '0;
						row_q   <= '0;
						dx_q    <= '0;
						dy_q    <= '0;
						black_q <= 1'b1;
					end
					gtfr_pkg::CMD_READ: begin
						rd_ok_q <= ridx_ext < IW'(FRAME_BYTES);
					end
					default: begin
					end
				endcase
			end
			if (cmd.dot_next || cmd.dot_skip) begin
				if (cmd.dot_next && dy_q != s_max) begin
					dy_q <= dy_q + SW'(1);
				end else if (cmd.dot_next && dx_q != s_max) begin
					dy_q <= '0;
					dx_q <= dx_q + SW'(1);
				end else begin
					dy_q <= '0;
					dx_q <= '0;
					if (row_q == 3'd6) begin
						row_q <= '0;
						col_q <= col_q + 3'd1;
					end else begin
						row_q <= row_q + 3'd1;
					end
				end
			end
			if (cmd.calc_coord) begin
				px_q <= cur_x_q + $signed(CW'(col_off)) + $signed(CW'(dx_q));
				py_q <= cur_y_q + $signed(CW'(7'(row_q * scale_q))) + $signed(CW'(dy_q));
			end
			if (cmd.calc_addr) begin
				addr_q <= idx[ADDR_W-1:0];
				ok_q   <= on_screen && (IW'(byte_col) < IW'(ROW_BYTES)) &&
					(idx < IW'(FRAME_BYTES));
				bit_q  <= 8'h80 >> panel_col[2:0];
			end
			if (cmd.cursor_upd) begin
				cur_x_q  <= wrap ? '0 : nx;
				cur_y_q  <= ny;
				halted_q <= ny > ($signed(CW'(SCREEN_HEIGHT)) - hh_s);
			end
			if (cmd.rd_capture) begin
				hold_q <= rd_ok_q ? ram_rdata : '0;
			end
			if (cmd.out_load) begin
				out_data_q <= hold_q;
				out_stop_q <= halted_q;
			end
		end
	end

	assign read_data    = out_data_q;
	assign text_stopped = out_stop_q;

	a_halt_from_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(halted_q) |-> $past(cmd.cursor_upd))
		else $error("text halt set outside a cursor update");
	a_write_after_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pix_wr |-> $past(cmd.calc_addr, 2))
		else $error("pixel write without a fresh address");
endmodule
`default_nettype wire

>>> rtl/gtfr_ctrl.sv
`default_nettype none
module gtfr_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [gtfr_pkg::CMD_W-1:0]  in_command,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output gtfr_pkg::dp_cmd_t                cmd,
	input  wire gtfr_pkg::dp_sts_t           sts
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FILL, S_DOT, S_COORD, S_ADDR, S_RD, S_WR, S_CURSOR,
		S_RDWAIT, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   char_q;
	logic   accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					priority if (in_command == gtfr_pkg::CMD_FILL) begin
						state_d = S_FILL;
					end else if (in_command == gtfr_pkg::CMD_PIXEL) begin
						state_d = S_ADDR;
					end else if (in_command == gtfr_pkg::CMD_CHAR && !sts.halted) begin
						state_d = S_DOT;
					end else if (in_command == gtfr_pkg::CMD_READ) begin
						state_d = S_RDWAIT;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_FILL: begin
				cmd.sweep_wr = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DONE;
				end
			end
			S_DOT: begin
				if (sts.dot_lit) begin
					state_d = S_COORD;
				end else if (sts.row_last) begin
					state_d = S_CURSOR;
				end else begin
					cmd.dot_skip = 1'b1;
				end
			end
			S_COORD: begin
				cmd.calc_coord = 1'b1;
				state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.calc_addr = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				state_d = S_WR;
			end
			S_WR: begin
				cmd.pix_wr = 1'b1;
				if (!char_q) begin
					state_d = S_DONE;
				end else if (sts.row_last && sts.sub_last) begin
					state_d = S_CURSOR;
				end else begin
					cmd.dot_next = 1'b1;
					state_d = S_DOT;
				end
			end
			S_CURSOR: begin
				cmd.cursor_upd = 1'b1;
				state_d = S_DONE;
			end
			S_RDWAIT: begin
				cmd.rd_capture = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
			char_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				char_q <= (in_command == gtfr_pkg::CMD_CHAR);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item taken while one is in work");
	a_result_posted: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("finished result not presented");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.pix_wr && !cmd.sweep_wr)
		else $error("frame store written while idle");
endmodule
`default_nettype wire

>>> rtl/glyph_text_framebuffer_renderer_unit.sv
// Text and pixel renderer into a 1-bit-per-pixel frame store held in panel order. Each input
// beat carries one command and yields exactly one output beat. After reset the store is
// swept to zero, one byte per cycle over all SCREEN_WIDTH*ROW_BYTES bytes (4000 by default),
// and no beat is taken until it ends. Items run one at a time through a single-port frame
// RAM: a fill sweeps every byte, a pixel is one read-modify-write, a read fetches one byte,
// start text loads the cursor and scale, and a character is skipped while text is stopped.
// A drawn character visits every dot of its 5x7 cell; a lit dot paints scale*scale pixels,
// each a read-modify-write of one byte. A new beat may be taken while the last result still
// waits on the output.
`default_nettype none
module glyph_text_framebuffer_renderer_unit #(
	parameter int SCREEN_WIDTH  = gtfr_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = gtfr_pkg::DEF_SCREEN_HEIGHT,
	parameter int ROW_BYTES     = gtfr_pkg::DEF_ROW_BYTES
) (
	input wire logic   clk,
	input wire logic   arst_n,
	gtfr_in_if.sink    in_ch,
	gtfr_out_if.source out_ch
);
	gtfr_pkg::dp_cmd_t cmd;
	gtfr_pkg::dp_sts_t sts;

	gtfr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_command (in_ch.command),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	gtfr_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.ROW_BYTES     (ROW_BYTES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command      (in_ch.command),
		.x_pos        (in_ch.x_pos),
		.y_pos        (in_ch.y_pos),
		.pixel_black  (in_ch.pixel_black),
		.fill_white   (in_ch.fill_white),
		.char_code    (in_ch.char_code),
		.text_scale   (in_ch.text_scale),
		.read_index   (in_ch.read_index),
		.read_data    (out_ch.read_data),
		.text_stopped (out_ch.text_stopped)
	);
endmodule
`default_nettype wire
